[design/lrrc_pkg.sv]
`default_nettype none
package lrrc_pkg;

  localparam int OFFSET_BITS_DEF = 32;

  localparam int KLIM_BITS   = 17;
  localparam int VLIM_BITS   = 25;
  localparam int CNT_BITS    = 25;
  localparam int CFG_IDX_BITS = 4;
  localparam int CFG_DATA_BITS = 25;
  localparam int GOFF_BITS   = 32;

  localparam logic [KLIM_BITS-1:0] KEY_LIMIT_RST   = 17'd65536;
  localparam logic [VLIM_BITS-1:0] VALUE_LIMIT_RST = 25'd16777216;

  localparam logic [CFG_IDX_BITS-1:0] CFG_KEY_LIMIT   = 4'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_VALUE_LIMIT = 4'd1;

  localparam logic [7:0] MAGIC_BYTE  = 8'h4B;
  localparam logic [7:0] OP_SET_BYTE = 8'h53;
  localparam logic [7:0] OP_DEL_BYTE = 8'h44;

  localparam logic [CNT_BITS:0] LEN_BYTES = 26'd8;
  localparam logic [CNT_BITS:0] CRC_BYTES = 26'd4;

  localparam logic [31:0] CRC_POLY = 32'hEDB88320;
  localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;

  localparam logic [1:0] ROLE_FRAME   = 2'd0;
  localparam logic [1:0] ROLE_KEY     = 2'd1;
  localparam logic [1:0] ROLE_VALUE   = 2'd2;
  localparam logic [1:0] ROLE_IGNORED = 2'd3;

  localparam logic [2:0] ST_BUSY      = 3'd0;
  localparam logic [2:0] ST_ACCEPTED  = 3'd1;
  localparam logic [2:0] ST_BAD_MAGIC = 3'd2;
  localparam logic [2:0] ST_BAD_OP    = 3'd3;
  localparam logic [2:0] ST_BAD_LEN   = 3'd4;
  localparam logic [2:0] ST_CRC_BAD   = 3'd5;
  localparam logic [2:0] ST_TRUNC     = 3'd6;
  localparam logic [2:0] ST_CLEAN_END = 3'd7;

  // reflected CRC-32, one byte
  function automatic logic [31:0] crc_byte(input logic [31:0] crc_in, input logic [7:0] b);
    logic [31:0] c;
    c = crc_in ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage
`default_nettype wire

[design/log_record_replay_checker_top.sv]
// A result item is presented in the cycle after its input item is accepted.
// Throughput: one byte item per cycle while out_ready is high; the byte-wide CRC update
// and the parser step both finish between the input handshake and the result register.
// Reset (rst, synchronous, active high) returns the parser to expecting a magic
// byte, clears offsets and the halt flag, and restores both length limits.
`default_nettype none
module log_record_replay_checker_top #(
  parameter int OFFSET_BITS = lrrc_pkg::OFFSET_BITS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [lrrc_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  wire logic [lrrc_pkg::CFG_DATA_BITS-1:0] cfg_data,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic [7:0]                        log_byte,
  input  wire logic                              end_of_log,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic [7:0]                             passed_byte,
  output logic [1:0]                             byte_role,
  output logic                                   record_op,
  output logic [2:0]                             status,
  output logic [16:0]                            key_length,
  output logic [24:0]                            value_length,
  output logic [31:0]                            good_offset
);

  typedef enum logic [5:0] {
    PH_MAGIC = 6'b000001,
    PH_OP    = 6'b000010,
    PH_LENS  = 6'b000100,
    PH_KEY   = 6'b001000,
    PH_VAL   = 6'b010000,
    PH_CRC   = 6'b100000
  } phase_t;

  localparam int CB = lrrc_pkg::CNT_BITS;
  localparam logic [OFFSET_BITS-1:0] OFFSET_MAX = {OFFSET_BITS{1'b1}};

  logic [lrrc_pkg::KLIM_BITS-1:0] key_limit;
  logic [lrrc_pkg::VLIM_BITS-1:0] value_limit;

  phase_t                 phase, phase_next;
  logic [CB-1:0]          cnt, cnt_next;
  logic [63:0]            hdr, hdr_next;
  logic                   op_del, op_del_next;
  logic [31:0]            crc, crc_next;
  logic [31:0]            rcrc, rcrc_next;
  logic [OFFSET_BITS-1:0] soff, soff_next;
  logic [OFFSET_BITS-1:0] lgo, lgo_next;
  logic                   halted, halted_next;
  logic                   magic_bad, magic_bad_next;
  logic                   op_bad, op_bad_next;

  logic [7:0]  res_byte;
  logic [1:0]  res_role;
  logic        res_op;
  logic [2:0]  res_status;
  logic [16:0] res_klen;
  logic [24:0] res_vlen;

  logic        in_accept;
  logic [CB:0] cnt_inc;
  logic [63:0] hdr_shifted, hdr_src;
  logic [31:0] klen_new, vlen_new, klen_cur, vlen_cur;
  logic        len_bad, show_len;
  logic [31:0] crc_upd, rcrc_shifted;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid || out_ready;
  assign in_accept = in_valid && in_ready;

  assign cnt_inc      = {1'b0, cnt} + 1'b1;
  assign hdr_shifted  = {hdr[55:0], log_byte};
  assign klen_cur     = hdr[63:32];
  assign vlen_cur     = hdr[31:0];
  assign klen_new     = hdr_shifted[63:32];
  assign vlen_new     = hdr_shifted[31:0];
  assign len_bad      = (klen_new == 32'd0) || (klen_new > 32'(key_limit)) ||
                        (vlen_new > 32'(value_limit));
  assign crc_upd      = lrrc_pkg::crc_byte(crc, log_byte);
  assign rcrc_shifted = {rcrc[23:0], log_byte};
  // the last length byte shows the fresh header on its own result
  assign hdr_src      = (phase == PH_LENS) ? hdr_shifted : hdr;

  always_comb begin
    phase_next     = phase;
    cnt_next       = cnt;
    hdr_next       = hdr;
    op_del_next    = op_del;
    crc_next       = crc;
    rcrc_next      = rcrc;
    soff_next      = soff;
    lgo_next       = lgo;
    halted_next    = halted;
    magic_bad_next = magic_bad;
    op_bad_next    = op_bad;
    res_byte       = log_byte;
    res_role       = lrrc_pkg::ROLE_FRAME;
    res_op         = 1'b0;
    res_status     = lrrc_pkg::ST_BUSY;
    show_len       = 1'b0;

    if (halted) begin
      res_byte = end_of_log ? 8'd0 : log_byte;
      res_role = lrrc_pkg::ROLE_IGNORED;
    end else if (end_of_log) begin
      res_byte    = 8'd0;
      res_role    = lrrc_pkg::ROLE_IGNORED;
      res_status  = (phase == PH_MAGIC) ? lrrc_pkg::ST_CLEAN_END : lrrc_pkg::ST_TRUNC;
      halted_next = 1'b1;
      show_len    = (phase == PH_KEY) || (phase == PH_VAL) || (phase == PH_CRC);
    end else begin
      if (soff != OFFSET_MAX) begin
        soff_next = soff + 1'b1;
      end
      case (phase)
        PH_MAGIC: begin
          magic_bad_next = (log_byte != lrrc_pkg::MAGIC_BYTE);
          crc_next       = lrrc_pkg::CRC_INIT;
          hdr_next       = 64'd0;
          cnt_next       = '0;
          rcrc_next      = 32'd0;
          phase_next     = PH_OP;
        end
        PH_OP: begin
          crc_next    = crc_upd;
          op_del_next = (log_byte == lrrc_pkg::OP_DEL_BYTE);
          op_bad_next = (log_byte != lrrc_pkg::OP_SET_BYTE) &&
                        (log_byte != lrrc_pkg::OP_DEL_BYTE);
          cnt_next    = '0;
          phase_next  = PH_LENS;
        end
        PH_LENS: begin
          crc_next = crc_upd;
          hdr_next = hdr_shifted;
          cnt_next = cnt_inc[CB-1:0];
          if (cnt_inc >= lrrc_pkg::LEN_BYTES) begin
            cnt_next = '0;
            show_len = 1'b1;
            // header checks: magic first, then lengths, then op
            if (magic_bad) begin
              res_status  = lrrc_pkg::ST_BAD_MAGIC;
              halted_next = 1'b1;
            end else if (len_bad) begin
              res_status  = lrrc_pkg::ST_BAD_LEN;
              halted_next = 1'b1;
            end else if (op_bad) begin
              res_status  = lrrc_pkg::ST_BAD_OP;
              halted_next = 1'b1;
            end else begin
              phase_next = PH_KEY;
            end
          end
        end
        PH_KEY: begin
          res_role = lrrc_pkg::ROLE_KEY;
          show_len = 1'b1;
          crc_next = crc_upd;
          cnt_next = cnt_inc[CB-1:0];
          if (32'(cnt_inc) >= klen_cur) begin
            cnt_next   = '0;
            phase_next = (vlen_cur != 32'd0) ? PH_VAL : PH_CRC;
          end
        end
        PH_VAL: begin
          res_role = lrrc_pkg::ROLE_VALUE;
          show_len = 1'b1;
          crc_next = crc_upd;
          cnt_next = cnt_inc[CB-1:0];
          if (32'(cnt_inc) >= vlen_cur) begin
            cnt_next   = '0;
            phase_next = PH_CRC;
          end
        end
        PH_CRC: begin
          show_len  = 1'b1;
          rcrc_next = rcrc_shifted;
          cnt_next  = cnt_inc[CB-1:0];
          if (cnt_inc >= lrrc_pkg::CRC_BYTES) begin
            cnt_next = '0;
            if ((crc ^ lrrc_pkg::CRC_INIT) == rcrc_shifted) begin
              res_status = lrrc_pkg::ST_ACCEPTED;
              res_op     = op_del;
              lgo_next   = soff_next;
              phase_next = PH_MAGIC;
            end else begin
              res_status  = lrrc_pkg::ST_CRC_BAD;
              halted_next = 1'b1;
            end
          end
        end
        default: begin
          phase_next = PH_MAGIC;
        end
      endcase
    end

    res_klen = show_len ? hdr_src[48:32] : 17'd0;
    res_vlen = show_len ? hdr_src[24:0] : 25'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key_limit   <= lrrc_pkg::KEY_LIMIT_RST;
      value_limit <= lrrc_pkg::VALUE_LIMIT_RST;
      phase       <= PH_MAGIC;
      cnt         <= '0;
      hdr         <= 64'd0;
      op_del      <= 1'b0;
      crc         <= lrrc_pkg::CRC_INIT;
      rcrc        <= 32'd0;
      soff        <= '0;
      lgo         <= '0;
      halted      <= 1'b0;
      magic_bad   <= 1'b0;
      op_bad      <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          lrrc_pkg::CFG_KEY_LIMIT:   key_limit   <= cfg_data[lrrc_pkg::KLIM_BITS-1:0];
          lrrc_pkg::CFG_VALUE_LIMIT: value_limit <= cfg_data[lrrc_pkg::VLIM_BITS-1:0];
          default: ;
        endcase
      end
      if (in_accept) begin
        phase     <= phase_next;
        cnt       <= cnt_next;
        hdr       <= hdr_next;
        op_del    <= op_del_next;
        crc       <= crc_next;
        rcrc      <= rcrc_next;
        soff      <= soff_next;
        lgo       <= lgo_next;
        halted    <= halted_next;
        magic_bad <= magic_bad_next;
        op_bad    <= op_bad_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      passed_byte  <= res_byte;
      byte_role    <= res_role;
      record_op    <= res_op;
      status       <= res_status;
      key_length   <= res_klen;
      value_length <= res_vlen;
      good_offset  <= lrrc_pkg::GOFF_BITS'(lgo_next);
    end
  end

  // once halted, every later item is echoed as ignored with no status
  assert property (@(posedge clk) disable iff (rst)
    in_accept && halted |=> out_valid && byte_role == lrrc_pkg::ROLE_IGNORED &&
      status == lrrc_pkg::ST_BUSY)
    else $error("halted block produced a live result");

  // an end of stream before halt always ends in truncated or clean end and halts
  assert property (@(posedge clk) disable iff (rst)
    in_accept && !halted && end_of_log |=> halted &&
      (status == lrrc_pkg::ST_TRUNC || status == lrrc_pkg::ST_CLEAN_END))
    else $error("end of stream not reported");

  // the good offset only moves forward
  assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> lgo >= $past(lgo))
    else $error("good offset moved backward");

  // acceptance comes only on a framing byte, with the op of the record
  assert property (@(posedge clk) disable iff (rst)
    in_accept && !halted && res_status == lrrc_pkg::ST_ACCEPTED |->
      phase == PH_CRC && res_role == lrrc_pkg::ROLE_FRAME && res_op == op_del)
    else $error("record accepted outside the CRC field");

endmodule
`default_nettype wire

[dv/tb.sv]
`timescale 1ns / 100ps
module tb;

  localparam int STALL_LIMIT = 2000;
  localparam int HOLD_CYCLES = 150;

  typedef enum logic [2:0] {SEEK_MAGIC, SEEK_OP, IN_LENS, IN_KEY, IN_VALUE, IN_CRC} phase_t;
  typedef enum int {END_BAD_MAGIC, END_BAD_OP, END_BAD_LEN, END_CRC_BAD, END_TRUNC, END_CLEAN}
    stream_end_t;

  typedef struct packed {
    logic [7:0]  pbyte;
    logic [1:0]  role;
    logic        op;
    logic [2:0]  st;
    logic [16:0] klen;
    logic [24:0] vlen;
    logic [31:0] goff;
  } echo_t;

  logic clk;
  logic rst;
  logic cfg_valid;
  logic cfg_ready;
  logic [lrrc_pkg::CFG_IDX_BITS-1:0] cfg_index;
  logic [lrrc_pkg::CFG_DATA_BITS-1:0] cfg_data;
  logic in_valid;
  logic in_ready;
  logic [7:0] log_byte;
  logic end_of_log;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [7:0] passed_byte;
  logic [1:0] byte_role;
  logic record_op;
  logic [2:0] status;
  logic [16:0] key_length;
  logic [24:0] value_length;
  logic [31:0] good_offset;

  log_record_replay_checker_top dut (.*);

  // parser mirror
  logic [lrrc_pkg::KLIM_BITS-1:0] key_lim = lrrc_pkg::KEY_LIMIT_RST;
  logic [lrrc_pkg::VLIM_BITS-1:0] val_lim = lrrc_pkg::VALUE_LIMIT_RST;
  phase_t phase = SEEK_MAGIC;
  logic [31:0] fcount = '0;
  logic [63:0] hdr = '0;
  logic del_op = 1'b0;
  logic magic_bad = 1'b0;
  logic op_bad = 1'b0;
  logic halted = 1'b0;
  logic [31:0] crc_acc = lrrc_pkg::CRC_INIT;
  logic [31:0] crc_rx = '0;
  logic [31:0] offs = '0;
  logic [31:0] good_offs = '0;

  echo_t echo_q[$];
  logic [7:0] rec_q[$];
  echo_t rx_want, rx_got;

  int err_cnt = 0;
  int items_sent = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_requests = 0;
  int hold_served = 0;
  int hold_left = 0;
  int idle_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic logic [31:0] crc_step(logic [31:0] crc, logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    repeat (8) c = (c >> 1) ^ (lrrc_pkg::CRC_POLY & {32{c[0]}});
    return c;
  endfunction

  function automatic echo_t parse_byte(logic [7:0] b, logic eol);
    echo_t e;
    logic [31:0] kl, vl;
    logic show;
    e = '0;
    kl = hdr[63:32];
    vl = hdr[31:0];
    if (halted) begin
      e.pbyte = eol ? 8'd0 : b;
      e.role = lrrc_pkg::ROLE_IGNORED;
      e.goff = good_offs;
      return e;
    end
    e.st = lrrc_pkg::ST_BUSY;
    e.role = lrrc_pkg::ROLE_FRAME;
    if (eol) begin
      e.st = (phase == SEEK_MAGIC) ? lrrc_pkg::ST_CLEAN_END : lrrc_pkg::ST_TRUNC;
      e.role = lrrc_pkg::ROLE_IGNORED;
      halted = 1'b1;
      b = 8'd0;
    end else begin
      if (offs != '1) offs++;
      case (phase)
        SEEK_MAGIC: begin
          magic_bad = (b != lrrc_pkg::MAGIC_BYTE);
          crc_acc = lrrc_pkg::CRC_INIT;
          hdr = '0;
          fcount = '0;
          crc_rx = '0;
          phase = SEEK_OP;
        end
        SEEK_OP: begin
          crc_acc = crc_step(crc_acc, b);
          del_op = (b == lrrc_pkg::OP_DEL_BYTE);
          op_bad = (b != lrrc_pkg::OP_SET_BYTE) && (b != lrrc_pkg::OP_DEL_BYTE);
          phase = IN_LENS;
          fcount = '0;
        end
        IN_LENS: begin
          crc_acc = crc_step(crc_acc, b);
          hdr = {hdr[55:0], b};
          fcount++;
          if (fcount >= lrrc_pkg::LEN_BYTES) begin
            kl = hdr[63:32];
            vl = hdr[31:0];
            fcount = '0;
            // header verdict order: magic, then lengths, then op
            if (magic_bad) begin
              e.st = lrrc_pkg::ST_BAD_MAGIC;
              halted = 1'b1;
            end else if (kl == 0 || kl > key_lim || vl > val_lim) begin
              e.st = lrrc_pkg::ST_BAD_LEN;
              halted = 1'b1;
            end else if (op_bad) begin
              e.st = lrrc_pkg::ST_BAD_OP;
              halted = 1'b1;
            end else begin
              phase = IN_KEY;
            end
          end
        end
        IN_KEY: begin
          e.role = lrrc_pkg::ROLE_KEY;
          crc_acc = crc_step(crc_acc, b);
          fcount++;
          if (fcount >= kl) begin
            fcount = '0;
            phase = (vl != 0) ? IN_VALUE : IN_CRC;
          end
        end
        IN_VALUE: begin
          e.role = lrrc_pkg::ROLE_VALUE;
          crc_acc = crc_step(crc_acc, b);
          fcount++;
          if (fcount >= vl) begin
            fcount = '0;
            phase = IN_CRC;
          end
        end
        default: begin
          crc_rx = {crc_rx[23:0], b};
          fcount++;
          if (fcount >= lrrc_pkg::CRC_BYTES) begin
            fcount = '0;
            if ((crc_acc ^ lrrc_pkg::CRC_INIT) == crc_rx) begin
              e.st = lrrc_pkg::ST_ACCEPTED;
              e.op = del_op;
              good_offs = offs;
              phase = SEEK_MAGIC;
            end else begin
              e.st = lrrc_pkg::ST_CRC_BAD;
              halted = 1'b1;
            end
          end
        end
      endcase
    end
    if (eol) show = (phase >= IN_KEY);
    else show = (phase >= IN_KEY) ||
                (e.st >= lrrc_pkg::ST_ACCEPTED && e.st <= lrrc_pkg::ST_CRC_BAD);
    e.pbyte = b;
    e.klen = show ? kl[16:0] : '0;
    e.vlen = show ? vl[24:0] : '0;
    e.goff = good_offs;
    return e;
  endfunction

  // record image in rec_q: magic, op, lengths, body, CRC (optionally corrupted)
  function automatic void build_record(logic [7:0] magic, logic [7:0] opb, logic [31:0] kl,
                                       logic [31:0] vl, int unsigned body,
                                       logic [31:0] crc_flip);
    logic [31:0] c;
    rec_q.delete();
    rec_q.push_back(magic);
    rec_q.push_back(opb);
    for (int i = 3; i >= 0; i--) rec_q.push_back(kl[8*i +: 8]);
    for (int i = 3; i >= 0; i--) rec_q.push_back(vl[8*i +: 8]);
    repeat (body) rec_q.push_back(8'($urandom));
    c = lrrc_pkg::CRC_INIT;
    for (int i = 1; i < rec_q.size(); i++) c = crc_step(c, rec_q[i]);
    c = ~c ^ crc_flip;
    for (int i = 3; i >= 0; i--) rec_q.push_back(c[8*i +: 8]);
  endfunction

  function automatic int unsigned pick_len(int unsigned lo, int unsigned lim);
    int unsigned cap;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: cap = 8;
      6, 7, 8: cap = 48;
      default: cap = 300;
    endcase
    if (cap > lim) cap = lim;
    return $urandom_range(lo, cap);
  endfunction

  function automatic void check_field(string name, longint unsigned exp, longint unsigned act);
    if (exp != act) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp, act);
      err_cnt++;
    end
  endfunction

  task automatic send_item(input logic [7:0] b, input logic eol);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    log_byte <= b;
    end_of_log <= eol;
    do @(posedge clk); while (!in_ready);
    echo_q.push_back(parse_byte(b, eol));
    items_sent++;
  endtask

  task automatic send_record_bytes(input int unsigned n);
    for (int i = 0; i < n; i++) send_item(rec_q[i], 1'b0);
  endtask

  task automatic send_good_record(input logic [7:0] opb, input logic [31:0] kl,
                                  input logic [31:0] vl);
    build_record(lrrc_pkg::MAGIC_BYTE, opb, kl, vl, kl + vl, '0);
    send_record_bytes(rec_q.size());
  endtask

  task automatic send_random_record();
    logic [31:0] kl, vl;
    kl = pick_len(1, key_lim);
    vl = ($urandom_range(0, 3) == 0) ? 0 : pick_len(0, val_lim);
    send_good_record($urandom_range(0, 1) ? lrrc_pkg::OP_DEL_BYTE : lrrc_pkg::OP_SET_BYTE,
                     kl, vl);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (echo_q.size() != 0);
  endtask

  task automatic write_limit(input logic [lrrc_pkg::CFG_IDX_BITS-1:0] idx,
                             input logic [lrrc_pkg::CFG_DATA_BITS-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == lrrc_pkg::CFG_KEY_LIMIT) key_lim = data[lrrc_pkg::KLIM_BITS-1:0];
    else val_lim = data[lrrc_pkg::VLIM_BITS-1:0];
    @(posedge clk);
  endtask

  task automatic set_limits(input logic [lrrc_pkg::CFG_DATA_BITS-1:0] kdata,
                            input logic [lrrc_pkg::CFG_DATA_BITS-1:0] vdata);
    wait_drained();
    write_limit(lrrc_pkg::CFG_KEY_LIMIT, kdata);
    write_limit(lrrc_pkg::CFG_VALUE_LIMIT, vdata);
  endtask

  task automatic test_directed();
    send_good_record(lrrc_pkg::OP_SET_BYTE, 1, 0);
    send_good_record(lrrc_pkg::OP_DEL_BYTE, 2, 3);
  endtask

  task automatic test_limit_sweep();
    logic [lrrc_pkg::CFG_DATA_BITS-1:0] sweep_k[4];
    logic [lrrc_pkg::CFG_DATA_BITS-1:0] sweep_v[4];
    sweep_k = '{25'd1, {8'd0, lrrc_pkg::KEY_LIMIT_RST}, 25'h001FFFF, 25'd3};
    sweep_v = '{25'd0, lrrc_pkg::VALUE_LIMIT_RST, 25'h1FFFFFF, 25'd5};
    for (int s = 0; s < 4; s++) begin
      set_limits(sweep_k[s], sweep_v[s]);
      // lengths right at the limits must pass
      if (key_lim <= 64 && val_lim <= 300)
        send_good_record(lrrc_pkg::OP_SET_BYTE, key_lim, val_lim);
      repeat (3) send_random_record();
    end
  endtask

  task automatic test_random_records(input int n);
    int stop_at;
    case ($urandom_range(0, 3))
      0: set_limits({8'd0, lrrc_pkg::KEY_LIMIT_RST}, lrrc_pkg::VALUE_LIMIT_RST);
      1: set_limits(lrrc_pkg::CFG_DATA_BITS'($urandom_range(1, 16)),
                    lrrc_pkg::CFG_DATA_BITS'($urandom_range(0, 16)));
      default: set_limits(lrrc_pkg::CFG_DATA_BITS'($urandom_range(1, 17'h1FFFF)),
                          lrrc_pkg::CFG_DATA_BITS'($urandom_range(0, 25'h1FFFFFF)));
    endcase
    stop_at = items_sent + n;
    while (items_sent < stop_at) send_random_record();
  endtask

  task automatic test_backpressure();
    // receiver stalls while the sender keeps offering, then sender waits for all results
    repeat (2) begin
      hold_requests++;
      repeat (3) send_random_record();
      wait_drained();
    end
  endtask

  task automatic test_longest_key();
    // key and value exactly at their configured limits, then a minimal delete record
    set_limits(lrrc_pkg::CFG_DATA_BITS'(40), lrrc_pkg::CFG_DATA_BITS'(90));
    send_good_record(lrrc_pkg::OP_SET_BYTE, 32'd40, 32'd90);
    send_good_record(lrrc_pkg::OP_DEL_BYTE, 32'd1, 32'd0);
  endtask

  // reset is never reasserted, so only one terminating case fits in a run
  task automatic test_stream_end();
    stream_end_t kind;
    logic [7:0] magic, opb;
    logic [31:0] kl, vl;
    int unsigned cut;
    set_limits(lrrc_pkg::CFG_DATA_BITS'($urandom_range(1, 64)),
               lrrc_pkg::CFG_DATA_BITS'($urandom_range(0, 64)));
    send_random_record();
    kind = stream_end_t'($urandom_range(0, 5));
    opb = $urandom_range(0, 1) ? lrrc_pkg::OP_DEL_BYTE : lrrc_pkg::OP_SET_BYTE;
    kl = pick_len(1, key_lim);
    vl = pick_len(0, val_lim);
    case (kind)
      END_BAD_MAGIC: begin
        do magic = 8'($urandom); while (magic == lrrc_pkg::MAGIC_BYTE);
        // bad magic wins over bad lengths and bad op
        build_record(magic, 8'($urandom), $urandom_range(0, 2), vl, 2, '0);
        send_record_bytes(rec_q.size());
      end
      END_BAD_OP: begin
        do opb = 8'($urandom);
        while (opb == lrrc_pkg::OP_SET_BYTE || opb == lrrc_pkg::OP_DEL_BYTE);
        build_record(lrrc_pkg::MAGIC_BYTE, opb, kl, vl, kl + vl, '0);
        send_record_bytes(rec_q.size());
      end
      END_BAD_LEN: begin
        if ($urandom_range(0, 1)) opb = 8'($urandom);
        case ($urandom_range(0, 3))
          0: kl = 0;
          1: kl = $urandom_range(0, 1) ? 32'hFFFFFFFF : key_lim + 1;
          2: vl = $urandom_range(0, 1) ? 32'hFFFFFFFF : val_lim + 1;
          default: set_limits({8'($urandom), 17'd0}, val_lim);
        endcase
        build_record(lrrc_pkg::MAGIC_BYTE, opb, kl, vl, 0, '0);
        send_record_bytes(rec_q.size());
      end
      END_CRC_BAD: begin
        build_record(lrrc_pkg::MAGIC_BYTE, opb, kl, vl, kl + vl,
                     32'd1 << $urandom_range(0, 31));
        send_record_bytes(rec_q.size());
      end
      END_TRUNC: begin
        build_record(lrrc_pkg::MAGIC_BYTE, opb, kl, vl, kl + vl, '0);
        cut = $urandom_range(1, rec_q.size() - 1);
        send_record_bytes(cut);
        send_item(8'($urandom), 1'b1);
      end
      default: send_item(8'($urandom), 1'b1);
    endcase
    // everything after the halt is echoed as ignored
    send_item(8'($urandom), 1'b1);
    repeat (24) send_item(8'($urandom), $urandom_range(0, 3) == 0);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (echo_q.size() == 0) begin
          $display("%0t: unexpected item, byte %h status %0d", $time, passed_byte, status);
          err_cnt++;
        end else begin
          rx_want = echo_q.pop_front();
          rx_got = {passed_byte, byte_role, record_op, status, key_length, value_length,
                    good_offset};
          check_field("passed_byte", rx_want.pbyte, rx_got.pbyte);
          check_field("byte_role", rx_want.role, rx_got.role);
          check_field("record_op", rx_want.op, rx_got.op);
          check_field("status", rx_want.st, rx_got.st);
          check_field("key_length", rx_want.klen, rx_got.klen);
          check_field("value_length", rx_want.vlen, rx_got.vlen);
          check_field("good_offset", rx_want.goff, rx_got.goff);
        end
      end
      if (hold_served != hold_requests) begin
        hold_served = hold_requests;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  initial begin
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    log_byte = '0;
    end_of_log = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = lrrc_pkg::CFG_KEY_LIMIT;
    cfg_data = '0;
    send_idle_pct = 12;
    recv_idle_pct = 78;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    test_directed();
    test_limit_sweep();
    test_random_records(60);

    send_idle_pct = 78;
    recv_idle_pct = 12;
    test_backpressure();
    test_random_records(60);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_records(60);
    test_longest_key();
    test_stream_end();

    wait_drained();
    repeat (4) @(posedge clk);
    if (err_cnt == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule
